// ===== rtl/cpuq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpuq_pkg: shared definitions of the coalescing priority update queue
// Widths, codes, the occupancy row layout and the structs passed between
// the control block and the occupancy store.
// ----------------------------------------------------------------------------
package cpuq_pkg;

    // Field widths.
    localparam int ID_W   = 10;
    localparam int KIND_W = 3;
    localparam int DIST_W = 24;
    localparam int LVL_W  = 3;
    localparam int MODE_W = 2;

    // Queue geometry.
    localparam int MAX_UNITS  = 1024;
    localparam int NUM_LEVELS = 6;
    localparam int WORD_W     = 32;
    localparam int NUM_ROWS   = MAX_UNITS / WORD_W;
    localparam int ROW_AW     = $clog2(NUM_ROWS);
    localparam int BIT_AW     = $clog2(WORD_W);
    localparam int KIND_AW    = $clog2(MAX_UNITS);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAX_RADIUS = 1'b0;

    // Command codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // Update kinds.
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PARTY      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_VISIBILITY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PROPERTIES = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POSITION   = 3'd5;

    // Level codes.
    localparam logic [LVL_W-1:0] LVL_NEAR_PROPS = 3'd2;
    localparam logic [LVL_W-1:0] LVL_FAR        = 3'd3;
    localparam logic [LVL_W-1:0] LVL_MID        = 3'd4;
    localparam logic [LVL_W-1:0] LVL_SMALL      = 3'd5;
    localparam logic [LVL_W-1:0] LVL_TOP        = 3'd0;
    localparam logic [LVL_W-1:0] LVL_VIS        = 3'd1;
    localparam logic [LVL_W-1:0] LVL_NONE       = 3'd7;

    // One occupancy row: one bit per id of the row, for each level.
    typedef logic [NUM_LEVELS-1:0][WORD_W-1:0] row_t;

    // Pop candidate chosen from the per-row level flags.
    typedef struct packed {
        logic              any;
        logic [LVL_W-1:0]  level;
        logic [ROW_AW-1:0] row;
    } pop_sel_t;

    // Write-back of one command into the store.
    typedef struct packed {
        logic               row_we;
        logic [ROW_AW-1:0]  row;
        row_t               data;
        logic               kind_we;
        logic [KIND_AW-1:0] kind_id;
        logic [KIND_W-1:0]  kind;
    } store_wr_t;

endpackage : cpuq_pkg
`default_nettype wire

// ===== rtl/cpuq_level_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpuq_level_map: update kind and distance to priority level
// Delete, create and party change map to level 0, visibility to 1.
// Position maps by distance against the radius; properties falls back to
// level 2 when the distance test picks nothing.
// ----------------------------------------------------------------------------
module cpuq_level_map
    import cpuq_pkg::*;
(
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [DIST_W-1:0] distance,
    input  wire logic [DIST_W-1:0] max_radius,
    output logic      [LVL_W-1:0]  level
);

    logic [DIST_W:0]  dist_ext;
    logic [DIST_W:0]  dist_x2;
    logic [DIST_W:0]  radius_ext;
    logic [DIST_W:0]  radius_x2;
    logic [LVL_W-1:0] dist_level;

    // Exact comparisons one bit wider than the operands.
    assign dist_ext   = {1'b0, distance};
    assign dist_x2    = {distance, 1'b0};
    assign radius_ext = {1'b0, max_radius};
    assign radius_x2  = {max_radius, 1'b0};

    // Distance test shared by position and properties.
    always_comb
    begin
        priority if (dist_ext > radius_x2)
            dist_level = LVL_FAR;
        else if (dist_x2 > radius_ext)
            dist_level = LVL_MID;
        else if (distance != '0)
            dist_level = LVL_SMALL;
        else
            dist_level = LVL_NONE;
    end

    // Kind selects the level or the distance test.
    always_comb
    begin
        unique case (kind)
            KIND_DELETE, KIND_CREATE, KIND_PARTY: level = LVL_TOP;
            KIND_VISIBILITY: level = LVL_VIS;
            KIND_PROPERTIES:
                level = (dist_level == LVL_NONE) ? LVL_NEAR_PROPS : dist_level;
            KIND_POSITION: level = dist_level;
            default: level = LVL_NONE;
        endcase
    end

endmodule : cpuq_level_map
`default_nettype wire

// ===== rtl/cpuq_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpuq_store: occupancy and kind memories of the update queue
// The occupancy memory holds one row per group of WORD_W ids, with one bit
// per id and level. Flip-flop flags mark which level of which row is
// non-empty; a row slice whose flag is clear reads as zero, so a clear only
// resets the flags. The flags also drive the pop search.
// ----------------------------------------------------------------------------
module cpuq_store
    import cpuq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [ROW_AW-1:0]  rd_row,
    input  wire logic [KIND_AW-1:0] rd_id,
    input  wire store_wr_t          wr,
    input  wire logic               clear_all,
    output row_t                    rd_data,
    output logic      [KIND_W-1:0]  rd_kind,
    output pop_sel_t                pop_sel,
    output logic                    empty
);

    row_t              occ_mem [NUM_ROWS];
    logic [KIND_W-1:0] kind_mem [MAX_UNITS];

    row_t              occ_rdata_reg;
    logic [KIND_W-1:0] kind_rdata_reg;
    logic [ROW_AW-1:0] rd_row_reg;

    logic [NUM_LEVELS-1:0][NUM_ROWS-1:0] nz_reg;
    logic [NUM_LEVELS-1:0][NUM_ROWS-1:0] nz_next;

    // Memory ports: one synchronous read and one write per memory.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            occ_rdata_reg  <= occ_mem[rd_row];
            kind_rdata_reg <= kind_mem[rd_id];
            rd_row_reg     <= rd_row;
        end
        if (wr.row_we)
            occ_mem[wr.row] <= wr.data;
        if (wr.kind_we)
            kind_mem[wr.kind_id] <= wr.kind;
    end

    // Slices of a row whose level flag is clear hold stale bits; they read as zero.
    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
            rd_data[l] = occ_rdata_reg[l] & {WORD_W{nz_reg[l][rd_row_reg]}};
    end

    assign rd_kind = kind_rdata_reg;

    // Level flags follow every row write; a clear drops them all.
    always_comb
    begin
        nz_next = nz_reg;
        if (clear_all)
            nz_next = '0;
        else if (wr.row_we)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
                nz_next[l][wr.row] = |wr.data[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nz_reg <= '0;
        else
            nz_reg <= nz_next;
    end

    // Pop search: lowest non-empty level, then its lowest non-empty row.
    always_comb
    begin
        pop_sel = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (|nz_reg[l])
            begin
                pop_sel.any   = 1'b1;
                pop_sel.level = LVL_W'(l);
            end
        end
        for (int r = NUM_ROWS - 1; r >= 0; r--)
        begin
            if (nz_reg[pop_sel.level][r])
                pop_sel.row = ROW_AW'(r);
        end
    end

    assign empty = ~|nz_reg;

`ifndef SYNTHESIS
    // A write that leaves the level 0 slice non-empty raises its flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.row_we && !clear_all && (|wr.data[0])) |=> nz_reg[0][$past(wr.row)])
        else $error("cpuq_store: level flag not set after row write");

    // A clear leaves the queue empty in the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> empty)
        else $error("cpuq_store: queue not empty after clear");

    // The pop candidate always points at a non-empty level and row.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_sel.any |-> nz_reg[pop_sel.level][pop_sel.row])
        else $error("cpuq_store: pop candidate on an empty row");
`endif

endmodule : cpuq_store
`default_nettype wire

// ===== rtl/coalescing_priority_update_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_priority_update_queue: six-level coalescing queue of unit ids
// Top level with the command handshake, the configuration port and the
// read-modify-write control of the occupancy store.
// ----------------------------------------------------------------------------
// Every command (push, pop, clear or no-op) reads, then writes back: in the
// cycle where start is taken, the occupancy row and the stored kind are
// read from the memories; in the next cycle busy is high while the row is
// modified and written back. The result appears with done for one cycle
// right after that, when busy is already low again, so a new command can
// be started once busy is low; the single read-modify-write pass over the
// occupancy memory takes no new command while one is in progress. Results
// cannot be held off by the receiver. Clear takes effect at once, with no
// sweep through the memory, and the queue is usable right after reset. Unit
// ids index a 1024-entry space; max_radius is written at APB byte address 0.
// ----------------------------------------------------------------------------
module coalescing_priority_update_queue
    import cpuq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Command channel.
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic [ID_W-1:0]    unit_id,
    input  wire logic [KIND_W-1:0]  update_kind,
    input  wire logic [DIST_W-1:0]  distance,
    // Result channel.
    output logic                    done,
    output logic                    pop_valid,
    output logic      [ID_W-1:0]    popped_id,
    output logic                    queue_empty,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    logic              done_reg;
    logic              pop_valid_reg;
    logic [ID_W-1:0]   popped_id_reg;
    logic [DIST_W-1:0] max_radius_reg;

    mode_t             mode_reg;
    logic [ID_W-1:0]   id_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DIST_W-1:0] dist_reg;
    pop_sel_t          pop_reg;

    logic              accept;
    logic [ROW_AW-1:0] rd_row;
    row_t              rd_data;
    logic [KIND_W-1:0] rd_kind;
    pop_sel_t          pop_sel;
    logic              store_empty;
    store_wr_t         wr;
    logic              clear_all;

    logic [LVL_W-1:0]  new_lvl;
    logic [LVL_W-1:0]  old_lvl;
    logic [BIT_AW-1:0] id_bit;
    logic [ROW_AW-1:0] id_row;
    logic              id_in_range;
    logic [WORD_W-1:0] pop_slice;
    logic [BIT_AW-1:0] pop_bit;
    logic              exec_pop_valid;
    logic [ID_W-1:0]   exec_popped_id;

    // A command transfer happens when start meets an idle block.
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Configuration register write and read back.
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_MAX_RADIUS)
                  ? PDATA_W'(max_radius_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_radius_reg <= '0;
        else if (psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1] == REG_MAX_RADIUS))
            max_radius_reg <= pwdata[DIST_W-1:0];
    end

    // Read address: the pop candidate's row or the pushed id's row.
    assign rd_row = (mode_t'(mode) == MODE_POP) ? pop_sel.row
                                                : unit_id[BIT_AW +: ROW_AW];

    cpuq_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_row    (rd_row),
        .rd_id     (unit_id[KIND_AW-1:0]),
        .wr        (wr),
        .clear_all (clear_all),
        .rd_data   (rd_data),
        .rd_kind   (rd_kind),
        .pop_sel   (pop_sel),
        .empty     (store_empty)
    );

    cpuq_level_map u_level_map (
        .kind       (kind_reg),
        .distance   (dist_reg),
        .max_radius (max_radius_reg),
        .level      (new_lvl)
    );

    // Command fields held for the modify cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(mode);
            id_reg   <= unit_id;
            kind_reg <= update_kind;
            dist_reg <= distance;
            pop_reg  <= pop_sel;
        end
    end

    assign id_bit      = id_reg[BIT_AW-1:0];
    assign id_row      = id_reg[BIT_AW +: ROW_AW];
    assign id_in_range = (32'(id_reg) < MAX_UNITS);

    // Current level of the pushed id: the one level bit set in its column.
    always_comb
    begin
        old_lvl = LVL_NONE;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (rd_data[l][id_bit])
                old_lvl = LVL_W'(l);
        end
    end

    // Lowest id of the pop candidate's slice.
    always_comb
    begin
        pop_slice = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (pop_reg.level == LVL_W'(l))
                pop_slice = rd_data[l];
        end
        pop_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (pop_slice[b])
                pop_bit = BIT_AW'(b);
        end
    end

    // Modify step: merge a push into the row, take the popped id out, or clear.
    always_comb
    begin
        wr             = '0;
        wr.data        = rd_data;
        wr.kind_id     = id_reg[KIND_AW-1:0];
        wr.kind        = kind_reg;
        clear_all      = 1'b0;
        exec_pop_valid = 1'b0;
        exec_popped_id = '0;
        if (state_reg == ST_EXEC)
        begin
            unique case (mode_reg)
                MODE_PUSH:
                begin
                    wr.row = id_row;
                    if (id_in_range)
                    begin
                        wr.row_we = 1'b1;
                        priority if (old_lvl != LVL_NONE && new_lvl != LVL_NONE
                                     && old_lvl < new_lvl)
                        begin
                            // A higher priority entry is kept as it is.
                        end
                        else if (old_lvl != LVL_NONE && old_lvl == new_lvl)
                        begin
                            // Same level: a delete cancels a pending create.
                            if (kind_reg == KIND_DELETE && rd_kind == KIND_CREATE)
                            begin
                                for (int l = 0; l < NUM_LEVELS; l++)
                                begin
                                    if (old_lvl == LVL_W'(l))
                                        wr.data[l][id_bit] = 1'b0;
                                end
                            end
                            else
                                wr.kind_we = 1'b1;
                        end
                        else
                        begin
                            // Move to the new level, or only remove.
                            for (int l = 0; l < NUM_LEVELS; l++)
                            begin
                                if (old_lvl == LVL_W'(l))
                                    wr.data[l][id_bit] = 1'b0;
                                if (new_lvl == LVL_W'(l))
                                    wr.data[l][id_bit] = 1'b1;
                            end
                            wr.kind_we = (new_lvl != LVL_NONE);
                        end
                    end
                end
                MODE_POP:
                begin
                    wr.row = pop_reg.row;
                    if (pop_reg.any)
                    begin
                        wr.row_we = 1'b1;
                        for (int l = 0; l < NUM_LEVELS; l++)
                        begin
                            if (pop_reg.level == LVL_W'(l))
                                wr.data[l][pop_bit] = 1'b0;
                        end
                        exec_pop_valid = 1'b1;
                        exec_popped_id = ID_W'({pop_reg.row, pop_bit});
                    end
                end
                MODE_CLEAR: clear_all = 1'b1;
                MODE_NOP: ;
                default: ;
            endcase
        end
    end

    // Sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            pop_valid_reg <= 1'b0;
            popped_id_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == ST_EXEC);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    state_reg     <= ST_IDLE;
                    pop_valid_reg <= exec_pop_valid;
                    popped_id_reg <= exec_popped_id;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done        = done_reg;
    assign pop_valid   = pop_valid_reg;
    assign popped_id   = popped_id_reg;
    assign queue_empty = store_empty;

`ifndef SYNTHESIS
    // A result only comes from a modify cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("cpuq: result without a modify cycle");

    // An accepted command always reaches the modify cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("cpuq: accepted command not executed");

    // A failed pop reports id zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pop_valid) |-> (popped_id == '0))
        else $error("cpuq: stale id on a result without pop");

    // A successful pop never leaves the queue reporting empty beforehand.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && mode_reg == MODE_POP && pop_reg.any) |->
        !store_empty)
        else $error("cpuq: pop candidate from an empty queue");
`endif

endmodule : coalescing_priority_update_queue
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the coalescing priority update queue
// Runs directed commands on the level mapping and the merge rules, then
// random traffic over several radius settings. A shadow copy of the queue
// in the bench predicts every result, and each result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import cpuq_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 315;
    localparam int NUM_PHASES      = 6;
    localparam int POOL_SIZE       = 16;
    localparam int DRAIN_CYCLES    = 8;

    // Kinds with no level: a push of these only removes a pending entry.
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam logic [PADDR_W-1:0] RADIUS_ADDR = PADDR_W'(4 * int'(REG_MAX_RADIUS));

    // One result of the block.
    typedef struct packed {
        logic            pop_valid;
        logic [ID_W-1:0] popped_id;
        logic            queue_empty;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [MODE_W-1:0]  mode = MODE_NOP;
    logic [ID_W-1:0]    unit_id = '0;
    logic [KIND_W-1:0]  update_kind = KIND_DELETE;
    logic [DIST_W-1:0]  distance = '0;
    logic               done;
    logic               pop_valid;
    logic [ID_W-1:0]    popped_id;
    logic               queue_empty;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow copy of the queue state and the radius register.
    logic [LVL_W-1:0]  shadow_level [MAX_UNITS];
    logic [KIND_W-1:0] shadow_kind [MAX_UNITS];
    int                shadow_count;
    logic [DIST_W-1:0] shadow_radius;

    outcome_t          outcome_q[$];
    logic [ID_W-1:0]   id_pool [POOL_SIZE];
    int                mismatch_count;
    int                cycle_count;
    bit                steady;

    coalescing_priority_update_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .unit_id     (unit_id),
        .update_kind (update_kind),
        .distance    (distance),
        .done        (done),
        .pop_valid   (pop_valid),
        .popped_id   (popped_id),
        .queue_empty (queue_empty),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Prints one mismatch and counts it.
    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        $display("mismatch at %0t: %s expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            report_mismatch(what, want, got);
        end
    endtask

    // Level that an update maps to; comparisons are exact at 26 bits.
    function automatic logic [LVL_W-1:0] level_of_update(logic [KIND_W-1:0] kind,
                                                        logic [DIST_W-1:0] dist_val);
        logic [25:0]      d_ext;
        logic [25:0]      r_ext;
        logic [LVL_W-1:0] lvl;
        d_ext = {2'b00, dist_val};
        r_ext = {2'b00, shadow_radius};
        lvl   = LVL_NONE;
        if (kind == KIND_DELETE || kind == KIND_CREATE || kind == KIND_PARTY)
        begin
            return LVL_TOP;
        end
        if (kind == KIND_VISIBILITY)
        begin
            return LVL_VIS;
        end
        if (kind == KIND_PROPERTIES)
        begin
            lvl = LVL_NEAR_PROPS;
        end
        // Properties falls through to the distance test as well.
        if (kind == KIND_PROPERTIES || kind == KIND_POSITION)
        begin
            if (d_ext > (r_ext << 1))
            begin
                lvl = LVL_FAR;
            end
            else if ((d_ext << 1) > r_ext)
            begin
                lvl = LVL_MID;
            end
            else if (d_ext != 0)
            begin
                lvl = LVL_SMALL;
            end
        end
        return lvl;
    endfunction

    function automatic void drop_entry(logic [ID_W-1:0] id);
        if (shadow_level[id] != LVL_NONE)
        begin
            shadow_level[id] = LVL_NONE;
            shadow_count--;
        end
    endfunction

    // Applies one command to the shadow queue and returns its result.
    function automatic outcome_t update_shadow_queue(mode_t m, logic [ID_W-1:0] id,
                                                     logic [KIND_W-1:0] kind,
                                                     logic [DIST_W-1:0] dist_val);
        outcome_t         res;
        logic [LVL_W-1:0] new_lvl;
        logic [LVL_W-1:0] old_lvl;
        bit               found;
        res   = '0;
        found = 1'b0;
        case (m)
            MODE_PUSH:
            begin
                new_lvl = level_of_update(kind, dist_val);
                old_lvl = shadow_level[id];
                if (old_lvl != LVL_NONE && new_lvl != LVL_NONE && old_lvl < new_lvl)
                begin
                    // A pending entry of higher priority wins.
                end
                else if (old_lvl != LVL_NONE && old_lvl == new_lvl)
                begin
                    if (kind == KIND_DELETE && shadow_kind[id] == KIND_CREATE)
                    begin
                        drop_entry(id);
                    end
                    else
                    begin
                        shadow_kind[id] = kind;
                    end
                end
                else
                begin
                    drop_entry(id);
                    if (new_lvl != LVL_NONE)
                    begin
                        shadow_level[id] = new_lvl;
                        shadow_kind[id]  = kind;
                        shadow_count++;
                    end
                end
            end
            MODE_POP:
            begin
                for (int lvl = 0; lvl < NUM_LEVELS && !found; lvl++)
                begin
                    for (int u = 0; u < MAX_UNITS && !found; u++)
                    begin
                        if (shadow_level[u] == LVL_W'(lvl))
                        begin
                            drop_entry(ID_W'(u));
                            res.pop_valid = 1'b1;
                            res.popped_id = ID_W'(u);
                            found         = 1'b1;
                        end
                    end
                end
            end
            MODE_CLEAR:
            begin
                foreach (shadow_level[u])
                begin
                    shadow_level[u] = LVL_NONE;
                end
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        res.queue_empty = (shadow_count == 0);
        return res;
    endfunction

    // Random gap on the command side: mostly none or short, a few long.
    task automatic idle_gap();
        int pick;
        int cycles;
        pick   = $urandom_range(0, 99);
        cycles = 0;
        if (!steady)
        begin
            if (pick >= 90)
            begin
                cycles = $urandom_range(4, 40);
            end
            else if (pick >= 55)
            begin
                cycles = $urandom_range(1, 3);
            end
        end
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Sends one command and records its predicted result at the transfer.
    task automatic send_command(mode_t m, logic [ID_W-1:0] id = '0,
                                logic [KIND_W-1:0] kind = KIND_DELETE,
                                logic [DIST_W-1:0] dist_val = '0);
        start       <= 1'b1;
        mode        <= m;
        unit_id     <= id;
        update_kind <= kind;
        distance    <= dist_val;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        outcome_q.push_back(update_shadow_queue(m, id, kind, dist_val));
        idle_gap();
    endtask

    // Waits until every predicted result has come and the block is quiet.
    task automatic wait_drained();
        while (outcome_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic read_radius(output logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RADIUS_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the radius while the block is idle and reads it back.
    task automatic write_radius(logic [DIST_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        // Stop the command side first so the last command is not taken again.
        start   <= 1'b0;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RADIUS_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        shadow_radius = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        read_radius(readback);
        compare_field("max_radius readback", PDATA_W'(value), readback);
    endtask

    // Distances around the thresholds of the current radius, plus noise.
    function automatic logic [DIST_W-1:0] pick_distance();
        logic [25:0] r2;
        logic [25:0] pick;
        r2 = {1'b0, shadow_radius, 1'b0};
        case ($urandom_range(0, 7))
            0:       pick = '0;
            1:       pick = 26'($urandom) & 26'hFFFFFF;
            2:       pick = r2;
            3:       pick = r2 + 1;
            4:       pick = 26'(shadow_radius >> 1);
            5:       pick = 26'(shadow_radius >> 1) + 1;
            6:       pick = 26'd1;
            default: pick = 26'($urandom_range(0, 32'(r2) + 2));
        endcase
        if (pick > 26'hFFFFFF)
        begin
            pick = 26'hFFFFFF;
        end
        return pick[DIST_W-1:0];
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        case ($urandom_range(0, 15))
            0, 1:              return KIND_DELETE;
            2, 3:              return KIND_CREATE;
            4:                 return KIND_PARTY;
            5, 6:              return KIND_VISIBILITY;
            7, 8:              return KIND_PROPERTIES;
            9, 10, 11, 12, 13: return KIND_POSITION;
            14:                return KIND_SPARE_6;
            default:           return KIND_SPARE_7;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 85)
        begin
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return ID_W'($urandom);
    endfunction

    // Pop and no-op on an empty queue, and the radius after reset.
    task automatic test_empty_queue();
        logic [PDATA_W-1:0] readback;
        read_radius(readback);
        compare_field("max_radius after reset", '0, readback);
        @(posedge clk);
        send_command(MODE_POP);
        send_command(MODE_NOP);
    endtask

    // A push to each level (two to the far level), then pops that must come out in level and id order.
    task automatic test_level_mapping();
        write_radius(24'h000100);
        send_command(MODE_PUSH, 10'd7, KIND_POSITION, 24'h000201);
        send_command(MODE_PUSH, 10'd8, KIND_POSITION, 24'h000081);
        send_command(MODE_PUSH, 10'd9, KIND_POSITION, 24'h000080);
        send_command(MODE_PUSH, 10'd10, KIND_PROPERTIES, 24'h000000);
        send_command(MODE_PUSH, 10'd11, KIND_VISIBILITY, 24'h000000);
        send_command(MODE_PUSH, 10'd0, KIND_PARTY, 24'hFFFFFF);
        send_command(MODE_PUSH, 10'd1023, KIND_POSITION, 24'hFFFFFF);
        repeat (8) send_command(MODE_POP);
    endtask

    // Coalescing of pushes on an id that already has an entry pending.
    task automatic test_merge_rules();
        // Delete of a pending create cancels it.
        send_command(MODE_PUSH, 10'd5, KIND_CREATE);
        send_command(MODE_PUSH, 10'd5, KIND_DELETE);
        // A lower priority push is dropped, a higher one moves the entry.
        send_command(MODE_PUSH, 10'd5, KIND_PARTY);
        send_command(MODE_PUSH, 10'd5, KIND_VISIBILITY);
        send_command(MODE_PUSH, 10'd6, KIND_POSITION, 24'h000001);
        send_command(MODE_PUSH, 10'd6, KIND_PROPERTIES, 24'h000000);
        // Position with no distance and the spare kinds only remove.
        send_command(MODE_PUSH, 10'd6, KIND_POSITION, 24'h000000);
        send_command(MODE_PUSH, 10'd4, KIND_SPARE_6);
        send_command(MODE_PUSH, 10'd5, KIND_SPARE_7);
        send_command(MODE_PUSH, 10'd4, KIND_VISIBILITY);
        send_command(MODE_CLEAR);
    endtask

    // Random traffic on a small id pool, one phase per radius setting.
    task automatic test_random_traffic();
        int sent;
        int pick;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       write_radius(24'h000000);
                1:       write_radius(24'hFFFFFF);
                2:       write_radius(24'h000100);
                3:       write_radius(24'h000001);
                4:       write_radius(DIST_W'($urandom_range(2, 24'h00FFFF)));
                default: write_radius(DIST_W'($urandom));
            endcase
            foreach (id_pool[p])
            begin
                id_pool[p] = ID_W'($urandom);
            end
            id_pool[0] = '0;
            id_pool[1] = '1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // Stretches without gaps now and then.
                if (sent % 40 == 0)
                begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 58)
                begin
                    send_command(MODE_PUSH, pick_id(), pick_kind(), pick_distance());
                    sent++;
                end
                else if (pick < 88)
                begin
                    send_command(MODE_POP);
                    sent++;
                end
                else if (pick < 90)
                begin
                    send_command(MODE_CLEAR);
                    sent++;
                end
                else if (pick < 92)
                begin
                    send_command(MODE_NOP);
                    sent++;
                end
                else
                begin
                    // Drain the queue with up to 24 pops, ending with a pop of the empty queue once it is empty.
                    for (int k = 0; k < 24 && sent < ITEMS_PER_PHASE; k++)
                    begin
                        if (shadow_count == 0)
                        begin
                            k = 24;
                        end
                        send_command(MODE_POP);
                        sent++;
                    end
                end
            end
            steady = 1'b0;
        end
    endtask

    // Each result is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                report_mismatch("result with nothing pending, popped_id", '0, 32'(popped_id));
            end
            else
            begin
                want = outcome_q.pop_front();
                compare_field("pop_valid", 32'(want.pop_valid), 32'(pop_valid));
                compare_field("popped_id", 32'(want.popped_id), 32'(popped_id));
                compare_field("queue_empty", 32'(want.queue_empty), 32'(queue_empty));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_level[u])
        begin
            shadow_level[u] = LVL_NONE;
            shadow_kind[u]  = KIND_DELETE;
        end
        shadow_count   = 0;
        shadow_radius  = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady         = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_level_mapping();
        test_merge_rules();
        test_random_traffic();

        start <= 1'b0;
        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule : tb
